@@ src/lptfc_pkg.sv @@
package lptfc_pkg;

  // Command codes carried in in_tuser.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_REALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE    = 2'd2;

  // Outcome codes carried in out_tuser.
  localparam logic [2:0] OUT_OK         = 3'd0;
  localparam logic [2:0] OUT_DOUBLE     = 3'd1;
  localparam logic [2:0] OUT_NEVER      = 3'd2;
  localparam logic [2:0] OUT_EARLY      = 3'd3;
  localparam logic [2:0] OUT_NULL       = 3'd4;

  localparam int FIELD_W  = 32;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;

endpackage

@@ src/live_pointer_tracker_free_checker_core.sv @@
// Channel | Ports                        | Contents
// --------+------------------------------+-----------------------------------------
// input   | in_tvalid/tready/tdata/tuser | tdata: address, new_address, request_size;
//         |                              | tuser: command
// result  | out_tvalid/tready/tdata/tuser| tdata: free_count, table_full; tuser: outcome
//
// A transfer is taken only in the idle state, so items are handled one at a time.
// A null free, an early free or the unused command goes from the idle state
// straight to the output state. An allocation probes the table for a free slot;
// a free that hits looks the address up and drops it; a reallocation that moves
// an address looks up the old one, drops it and inserts the new one. Each table
// probe is a read, then a check against the registered read data of the
// single-port slot memory. A free that misses the table scans the recent-free
// ring entry by entry, up to RING_DEPTH entries. After reset a clearing pass zeroes
// both memories while in_tready stays low. A result waits in the output
// register while the next transfer on the input side is already taken; the
// block stalls in its output state while that register is still full.
module live_pointer_tracker_free_checker_core #(
  parameter int TABLE_SLOTS = 16384,
  parameter int RING_DEPTH  = 1024,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] address, [63:32] new_address, [95:64] request_size
  input  logic [95:0] in_tdata,
  // [1:0] command
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] free_count, [32] table_full, [39:33] zero
  output logic [39:0] out_tdata,
  // [2:0] outcome
  output logic [2:0]  out_tuser
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int RING_W = $clog2(RING_DEPTH);
  localparam int CLR_N  = (TABLE_SLOTS > RING_DEPTH) ? TABLE_SLOTS : RING_DEPTH;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam logic [ADDR_WIDTH-1:0] TOMB = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LRD, S_LCHK, S_RACT, S_DROP, S_INS0, S_IRD, S_ICHK,
    S_RRD, S_RCHK, S_OUT
  } state_t;

  state_t               state_r;
  logic [1:0]           cmd_r;
  logic [ADDR_WIDTH-1:0] old_r, new_r;
  logic                 size_zero_r;
  logic [IDX_W-1:0]     idx_r, found_idx_r;
  logic [IDX_W:0]       cnt_r;
  logic                 found_r;
  logic                 started_r;
  logic [RING_W-1:0]    ring_pos_r, scan_r;
  logic [31:0]          free_cnt_r;
  logic                 full_r;
  logic [2:0]           outcome_r;
  logic [CLR_W-1:0]     clr_r;
  logic                 out_valid_r;
  logic [31:0]          out_cnt_r;
  logic                 out_full_r;
  logic [2:0]           out_outcome_r;

  logic [ADDR_WIDTH-1:0] in_old, in_new;
  logic [IDX_W-1:0]      in_old_hash, new_hash;
  logic                  in_acc;

  logic                  slot_we, ring_we;
  logic [IDX_W-1:0]      slot_addr;
  logic [ADDR_WIDTH-1:0] slot_wdata, slot_rdata;
  logic [RING_W-1:0]     ring_addr;
  logic [ADDR_WIDTH-1:0] ring_wdata, ring_rdata;

  assign in_old      = ADDR_WIDTH'(in_tdata[31:0]);
  assign in_new      = ADDR_WIDTH'(in_tdata[63:32]);
  assign in_old_hash = IDX_W'((in_old >> 4) ^ (in_old >> 16));
  assign new_hash    = IDX_W'((new_r >> 4) ^ (new_r >> 16));
  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;

  // Memory port steering: clearing pass, probe reads, tombstone and insert
  // writes, ring writes and ring scan reads.
  always_comb begin
    slot_we    = 1'b0;
    slot_addr  = idx_r;
    slot_wdata = new_r;
    ring_we    = 1'b0;
    ring_addr  = scan_r;
    ring_wdata = old_r;
    case (state_r)
      S_CLEAR: begin
        slot_addr  = IDX_W'(clr_r);
        slot_wdata = '0;
        slot_we    = ({1'b0, clr_r} < (CLR_W+1)'(TABLE_SLOTS));
        ring_addr  = RING_W'(clr_r);
        ring_wdata = '0;
        ring_we    = ({1'b0, clr_r} < (CLR_W+1)'(RING_DEPTH));
      end
      S_DROP: begin
        slot_addr  = found_idx_r;
        slot_wdata = TOMB;
        slot_we    = 1'b1;
        ring_addr  = ring_pos_r;
        ring_we    = (cmd_r == lptfc_pkg::CMD_FREE);
      end
      S_ICHK: begin
        slot_we = (slot_rdata == '0) || (slot_rdata == TOMB) || (slot_rdata == new_r);
      end
      default: begin
      end
    endcase
  end

  lptfc_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(TABLE_SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .addr(slot_addr), .wdata(slot_wdata), .rdata(slot_rdata)
  );

  lptfc_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk(clk), .we(ring_we), .addr(ring_addr), .wdata(ring_wdata), .rdata(ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      started_r   <= 1'b0;
      ring_pos_r  <= '0;
      free_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The output state reloads the register itself, so it owns the flag then.
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLR_W'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd_r       <= in_tuser;
            old_r       <= in_old;
            new_r       <= in_new;
            size_zero_r <= (in_tdata[95:64] == '0);
            outcome_r   <= lptfc_pkg::OUT_OK;
            full_r      <= 1'b0;
            found_r     <= 1'b0;
            idx_r       <= in_old_hash;
            cnt_r       <= '0;
            scan_r      <= '0;
            case (in_tuser)
              lptfc_pkg::CMD_ALLOC: begin
                started_r <= 1'b1;
                state_r   <= S_INS0;
              end
              lptfc_pkg::CMD_REALLOC: begin
                started_r <= 1'b1;
                state_r   <= (in_old != '0 && in_old != TOMB) ? S_LRD : S_RACT;
              end
              lptfc_pkg::CMD_FREE: begin
                if (in_old == '0) begin
                  outcome_r <= lptfc_pkg::OUT_NULL;
                  state_r   <= S_OUT;
                end else begin
                  free_cnt_r <= free_cnt_r + 1'b1;
                  if (!started_r) begin
                    outcome_r <= lptfc_pkg::OUT_EARLY;
                    state_r   <= S_OUT;
                  end else if (in_old == TOMB) begin
                    state_r <= S_RRD;
                  end else begin
                    state_r <= S_LRD;
                  end
                end
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_LRD: begin
          state_r <= S_LCHK;
        end
        S_LCHK: begin
          if (slot_rdata == '0 || slot_rdata == old_r ||
              cnt_r == (IDX_W+1)'(TABLE_SLOTS - 1)) begin
            found_r     <= (slot_rdata == old_r);
            found_idx_r <= idx_r;
            if (cmd_r == lptfc_pkg::CMD_FREE) begin
              state_r <= (slot_rdata == old_r) ? S_DROP : S_RRD;
            end else begin
              state_r <= S_RACT;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_LRD;
          end
        end
        S_RACT: begin
          // Drop the old address when the realloc moved or freed it.
          if (found_r && old_r != '0 && (new_r != '0 || size_zero_r)) begin
            state_r <= S_DROP;
          end else if (new_r != '0) begin
            state_r <= S_INS0;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DROP: begin
          if (cmd_r == lptfc_pkg::CMD_FREE) begin
            ring_pos_r <= (ring_pos_r == RING_W'(RING_DEPTH - 1)) ? '0 : ring_pos_r + 1'b1;
            state_r    <= S_OUT;
          end else begin
            state_r <= (new_r != '0) ? S_INS0 : S_OUT;
          end
        end
        S_INS0: begin
          idx_r   <= new_hash;
          cnt_r   <= '0;
          state_r <= (new_r == '0 || new_r == TOMB) ? S_OUT : S_IRD;
        end
        S_IRD: begin
          state_r <= S_ICHK;
        end
        S_ICHK: begin
          if (slot_we) begin
            state_r <= S_OUT;
          end else if (cnt_r == (IDX_W+1)'(TABLE_SLOTS - 1)) begin
            full_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_IRD;
          end
        end
        S_RRD: begin
          state_r <= S_RCHK;
        end
        S_RCHK: begin
          if (ring_rdata == old_r) begin
            outcome_r <= lptfc_pkg::OUT_DOUBLE;
            state_r   <= S_OUT;
          end else if (scan_r == RING_W'(RING_DEPTH - 1)) begin
            outcome_r <= lptfc_pkg::OUT_NEVER;
            state_r   <= S_OUT;
          end else begin
            scan_r  <= scan_r + 1'b1;
            state_r <= S_RRD;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r   <= 1'b1;
            out_cnt_r     <= free_cnt_r;
            out_full_r    <= full_r;
            out_outcome_r <= outcome_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_full_r, out_cnt_r};
  assign out_tuser  = out_outcome_r;

  a_outcome_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= lptfc_pkg::OUT_NULL))
    else $error("outcome code out of range");

  a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != lptfc_pkg::OUT_OK) |-> !out_tdata[32])
    else $error("table full reported on a free");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("input taken during clearing pass");

endmodule

@@ src/lptfc_ram.sv @@
module lptfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
